// File: rtl/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types, signature constants and result codes for the byte signature
// scanner.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int POS_BITS = 24;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [47:0] SIG_LA1 = 48'hA9_00_85_02_A9_36;
  localparam logic [47:0] SIG_LA2 = 48'hA9_00_8D_00_DD_A9;
  localparam logic [47:0] SIG_LA3 = 48'h78_A9_7F_8D_0D_DC;
  localparam logic [39:0] SIG_MAG = 40'h4B_52_41_43_4B;
  localparam logic [47:0] SIG_FMT = 48'hEE_00_1C_AD_00_1C;
  localparam logic [31:0] SIG_PUB = 32'h52_41_49_4E;

  localparam int FLAG_LA1 = 0;
  localparam int FLAG_LA2 = 1;
  localparam int FLAG_LA3 = 2;
  localparam int FLAG_MAG = 3;
  localparam int FLAG_FMT = 4;
  localparam int FLAG_PUB = 5;
  localparam int NUM_FLAGS = 6;

  localparam logic [POS_BITS-1:0] TAG_LEAD    = POS_BITS'(4);
  localparam logic [POS_BITS-1:0] VOL_OFFSET  = POS_BITS'(6);
  localparam logic [POS_BITS-1:0] ISS_OFFSET  = POS_BITS'(7);
  localparam logic [POS_BITS:0]   TAG_SPAN    = (POS_BITS+1)'(10);

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_LA   = 3'd1;
  localparam logic [2:0] KIND_MAG  = 3'd2;
  localparam logic [2:0] KIND_FMT  = 3'd3;
  localparam logic [2:0] KIND_PUB  = 3'd4;
  localparam int NUM_KINDS = 5;

  localparam logic [6:0] CONF_LA  = 7'd95;
  localparam logic [6:0] CONF_MAG = 7'd90;
  localparam logic [6:0] CONF_FMT = 7'd85;
  localparam logic [6:0] CONF_PUB = 7'd80;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [NUM_FLAGS-1:0] flags;
    logic [7:0]           volume;
    logic [7:0]           issue;
  } summary_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [6:0] conf_of(input logic [2:0] kind);
    logic [6:0] c;
    unique case (kind)
      KIND_LA:  c = CONF_LA;
      KIND_MAG: c = CONF_MAG;
      KIND_FMT: c = CONF_FMT;
      KIND_PUB: c = CONF_PUB;
      default:  c = 7'd0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/bss_if.sv
// ----------------------------------------------------------------------------
// bss_if
// Valid/ready channels: image bytes in, scan results out.
// ----------------------------------------------------------------------------
interface bss_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface bss_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [6:0] confidence;
  logic [1:0] variant;
  logic [7:0] volume;
  logic [7:0] issue;
  logic       last_result;

  modport source (output valid, output kind, output confidence, output variant,
                  output volume, output issue, output last_result, input ready);
  modport sink   (input valid, input kind, input confidence, input variant,
                  input volume, input issue, input last_result, output ready);
endinterface

// File: rtl/byte_signature_scanner.sv
// ----------------------------------------------------------------------------
// byte_signature_scanner
// Scans an image buffer byte by byte for six fixed signatures and reports
// one result per family found, or one none result, at the end of each buffer.
// ----------------------------------------------------------------------------
// One byte is taken every cycle; the compare, count and capture logic in the
// intake works on a single byte per clock. On the final byte a summary goes
// into a two-entry queue, and the sequencer drains it as one to four results,
// one per cycle while the sink is ready. The intake stalls only when the
// queue is full, i.e. when the sink holds off or when buffers shorter than
// their result runs follow one another. Results leave through a registered
// output stage. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module byte_signature_scanner (
  input  logic          clk,
  input  logic          rst_n,
  bss_byte_if.sink      in_ch,
  bss_result_if.source  out_ch
);
  import bss_pkg::*;

  logic      push;
  summary_t  push_data;
  logic      pop;
  summary_t  pop_data;
  q_status_t q_status;

  bss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  bss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  bss_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .q_data   (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// File: rtl/bss_front.sv
// ----------------------------------------------------------------------------
// bss_front
// Byte intake: history window, signature compare, position count and tag
// capture. Pushes one summary per buffer into the queue.
// ----------------------------------------------------------------------------
module bss_front (
  input  logic                 clk,
  input  logic                 rst_n,
  bss_byte_if.sink             in_ch,
  input  bss_pkg::q_status_t   q_status,
  output logic                 push,
  output bss_pkg::summary_t    push_data
);
  import bss_pkg::*;

  logic [39:0]          history_r, history_nxt;
  logic [NUM_FLAGS-1:0] flags_r, flags_nxt;
  logic [POS_BITS-1:0]  count_r, count_nxt;
  logic [POS_BITS-1:0]  start_r, start_nxt;
  logic [7:0]           vol_r, vol_nxt;
  logic [7:0]           iss_r, iss_nxt;

  logic [47:0]          window;
  logic                 fire;
  logic                 unsat;
  logic [POS_BITS-1:0]  offset;
  logic [NUM_FLAGS-1:0] hits;
  logic                 tag_ok;

  assign in_ch.ready = !q_status.full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign window      = {history_r, in_ch.data_byte};
  assign unsat       = count_r != POS_MAX;
  assign offset      = count_r - start_r;

  always_comb begin
    hits           = '0;
    hits[FLAG_LA1] = (window == SIG_LA1) && (count_r >= POS_BITS'(5));
    hits[FLAG_LA2] = (window == SIG_LA2) && (count_r >= POS_BITS'(5));
    hits[FLAG_LA3] = (window == SIG_LA3) && (count_r >= POS_BITS'(5));
    hits[FLAG_MAG] = (window[39:0] == SIG_MAG) && (count_r >= POS_BITS'(4));
    hits[FLAG_FMT] = (window == SIG_FMT) && (count_r >= POS_BITS'(5));
    hits[FLAG_PUB] = (window[31:0] == SIG_PUB) && (count_r >= POS_BITS'(3));
  end

  always_comb begin
    history_nxt = history_r;
    flags_nxt   = flags_r;
    count_nxt   = count_r;
    start_nxt   = start_r;
    vol_nxt     = vol_r;
    iss_nxt     = iss_r;
    if (fire) begin
      if (flags_r[FLAG_MAG] && unsat) begin
        if (offset == VOL_OFFSET) begin
          vol_nxt = in_ch.data_byte;
        end else if (offset == ISS_OFFSET) begin
          iss_nxt = in_ch.data_byte;
        end
      end
      flags_nxt = flags_r | hits;
      if (!flags_r[FLAG_MAG] && hits[FLAG_MAG]) begin
        start_nxt = count_r - TAG_LEAD;
      end
      history_nxt = window[39:0];
      if (unsat) begin
        count_nxt = count_r + POS_BITS'(1);
      end
    end
  end

  assign tag_ok = ({1'b0, start_nxt} + TAG_SPAN) < {1'b0, count_nxt};

  assign push             = fire && in_ch.final_byte;
  assign push_data.flags  = flags_nxt;
  assign push_data.volume = tag_ok ? vol_nxt : 8'd0;
  assign push_data.issue  = tag_ok ? iss_nxt : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      history_r <= '0;
      flags_r   <= '0;
      count_r   <= '0;
      start_r   <= '0;
      vol_r     <= '0;
      iss_r     <= '0;
    end else begin
      history_r <= history_nxt;
      flags_r   <= flags_nxt;
      count_r   <= count_nxt;
      start_r   <= start_nxt;
      vol_r     <= vol_nxt;
      iss_r     <= iss_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (count_r == '0) && (flags_r == '0))
    else $error("front state not cleared after final byte");

  a_flags_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !in_ch.final_byte) |=> ((flags_r & $past(flags_r)) == $past(flags_r)))
    else $error("found flag dropped mid-buffer");

  a_start_behind_count: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r[FLAG_MAG] |-> (({1'b0, start_r} + (POS_BITS+1)'(4)) <= {1'b0, count_r}))
    else $error("tag start ahead of byte count");
`endif

endmodule

// File: rtl/bss_queue.sv
// ----------------------------------------------------------------------------
// bss_queue
// Short summary queue between intake and result sequencer.
// ----------------------------------------------------------------------------
module bss_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bss_pkg::summary_t   push_data,
  input  logic                pop,
  output bss_pkg::summary_t   pop_data,
  output bss_pkg::q_status_t  status
);
  import bss_pkg::*;

  summary_t              mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0]   fill_r, fill_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign status.full  = fill_r == QUEUE_CW'(QUEUE_DEPTH);
  assign status.empty = fill_r == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QUEUE_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QUEUE_AW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + QUEUE_CW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("pop from empty queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue fill out of range");
`endif

endmodule

// File: rtl/bss_back.sv
// ----------------------------------------------------------------------------
// bss_back
// Result sequencer: expands one summary into its result run, one result per
// transfer, through a registered output stage.
// ----------------------------------------------------------------------------
module bss_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bss_pkg::q_status_t  q_status,
  input  bss_pkg::summary_t   q_data,
  output logic                pop,
  bss_result_if.source        out_ch
);
  import bss_pkg::*;

  logic                 busy_r;
  logic [NUM_KINDS-1:0] mask_r;
  logic [1:0]           variant_r;
  logic [7:0]           vol_r;
  logic [7:0]           iss_r;

  logic                 valid_r;
  logic [2:0]           kind_r;
  logic [6:0]           conf_r;
  logic [1:0]           ovar_r;
  logic [7:0]           ovol_r;
  logic [7:0]           oiss_r;
  logic                 last_r;

  logic                 load;
  logic                 emit;
  logic [2:0]           sel_kind;
  logic [NUM_KINDS-1:0] rest;
  logic                 last_emit;
  logic [NUM_KINDS-1:0] new_mask;
  logic [1:0]           new_variant;

  always_comb begin
    sel_kind = KIND_NONE;
    for (int k = NUM_KINDS - 1; k >= 0; k--) begin
      if (mask_r[k]) begin
        sel_kind = 3'(k);
      end
    end
  end

  always_comb begin
    rest           = mask_r;
    rest[sel_kind] = 1'b0;
  end

  assign last_emit = rest == '0;
  assign load      = !valid_r || out_ch.ready;
  assign emit      = load && busy_r;
  assign pop       = !q_status.empty && (!busy_r || (emit && last_emit));

  always_comb begin
    new_mask           = '0;
    new_mask[KIND_LA]  = |q_data.flags[FLAG_LA3:FLAG_LA1];
    new_mask[KIND_MAG] = q_data.flags[FLAG_MAG];
    new_mask[KIND_FMT] = q_data.flags[FLAG_FMT];
    new_mask[KIND_PUB] = q_data.flags[FLAG_PUB];
    new_mask[KIND_NONE] = ~|q_data.flags;
    if (q_data.flags[FLAG_LA1]) begin
      new_variant = 2'd1;
    end else if (q_data.flags[FLAG_LA2]) begin
      new_variant = 2'd2;
    end else begin
      new_variant = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mask_r <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      mask_r <= new_mask;
    end else if (emit) begin
      busy_r <= !last_emit;
      mask_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      variant_r <= new_variant;
      vol_r     <= q_data.volume;
      iss_r     <= q_data.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (emit) begin
      valid_r <= 1'b1;
    end else if (load) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= sel_kind;
      conf_r <= conf_of(sel_kind);
      ovar_r <= (sel_kind == KIND_LA) ? variant_r : 2'd0;
      ovol_r <= (sel_kind == KIND_MAG) ? vol_r : 8'd0;
      oiss_r <= (sel_kind == KIND_MAG) ? iss_r : 8'd0;
      last_r <= last_emit;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.confidence  = conf_r;
  assign out_ch.variant     = ovar_r;
  assign out_ch.volume      = ovol_r;
  assign out_ch.issue       = oiss_r;
  assign out_ch.last_result = last_r;

`ifndef NO_ASSERTIONS
  a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (mask_r != '0))
    else $error("sequencer busy with empty result mask");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (kind_r == KIND_NONE)) |-> last_r)
    else $error("none result not marked last");

  a_idle_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && q_status.empty) |=> (!valid_r || $past(valid_r)))
    else $error("result produced with no summary pending");
`endif

endmodule

// File: tb/sv/tb_byte_signature_scanner.sv
// ----------------------------------------------------------------------------
// tb_byte_signature_scanner
// Self-checking bench for the byte signature scanner. Image buffers built from
// whole, broken and partial signatures plus noise are streamed in. A scoreboard
// tracks the found flags, positions and tag bytes and works out the report run
// that each final byte should produce. Every result transfer is compared with
// the oldest pending report. Phases vary source gaps and sink stalls, and one
// phase holds the sink off long enough to back the input up.
// ----------------------------------------------------------------------------
module tb_byte_signature_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import bss_pkg::*;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] confidence;
    logic [1:0] variant;
    logic [7:0] volume;
    logic [7:0] issue;
    logic       last_result;
  } report_t;

  // signatures right-aligned, first byte most significant; indexed by flag bit
  localparam logic [47:0] SIG_BYTES [NUM_FLAGS] = '{
    48'hA9_00_85_02_A9_36, 48'hA9_00_8D_00_DD_A9, 48'h78_A9_7F_8D_0D_DC,
    48'h00_4B_52_41_43_4B, 48'hEE_00_1C_AD_00_1C, 48'h00_00_52_41_49_4E};
  localparam int SIG_LEN [NUM_FLAGS] = '{6, 6, 6, 5, 6, 4};

  localparam logic [6:0] LOADER_CONF    = 7'd95;
  localparam logic [6:0] MAGAZINE_CONF  = 7'd90;
  localparam logic [6:0] FORMATTER_CONF = 7'd85;
  localparam logic [6:0] PUBLISHER_CONF = 7'd80;
  localparam int VOLUME_AT = 6;
  localparam int ISSUE_AT  = 7;
  localparam int TAG_REACH = 10;

  logic clk;
  logic rst_n;

  bss_byte_if   in_ch ();
  bss_result_if out_ch ();

  byte_signature_scanner u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // scoreboard state
  logic [39:0]         scan_hist;
  logic [NUM_FLAGS-1:0] scan_flags;
  logic [POS_BITS-1:0] scan_count;
  logic [POS_BITS-1:0] tag_pos;
  logic [7:0]          tag_vol;
  logic [7:0]          tag_iss;

  report_t    due_reports [$];
  logic [7:0] img [$];
  int errors = 0;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("** byte_signature_scanner: FAILED **");
    $finish;
  end

  function automatic logic sig_hit(input logic [47:0] win, input int idx,
                                   input logic [POS_BITS-1:0] pos);
    logic [47:0] mask;
    mask = (48'h1 << (8 * SIG_LEN[idx])) - 48'h1;
    if (pos < POS_BITS'(SIG_LEN[idx] - 1)) return 1'b0;
    return ((win ^ SIG_BYTES[idx]) & mask) == 48'h0;
  endfunction

  task automatic clear_scan();
    scan_hist  = '0;
    scan_flags = '0;
    scan_count = '0;
    tag_pos    = '0;
    tag_vol    = '0;
    tag_iss    = '0;
  endtask

  task automatic track_signatures(input logic [7:0] b, input logic fin);
    logic [47:0]         win;
    logic [POS_BITS-1:0] pos;
    logic [POS_BITS-1:0] off;
    logic                unsat;
    logic                span_ok;
    logic [1:0]          v;
    report_t             run [4];
    int                  n;
    win   = {scan_hist, b};
    pos   = scan_count;
    unsat = scan_count != '1;
    if (scan_flags[FLAG_MAG] && unsat) begin
      off = pos - tag_pos;
      if (off == POS_BITS'(VOLUME_AT)) tag_vol = b;
      else if (off == POS_BITS'(ISSUE_AT)) tag_iss = b;
    end
    for (int i = 0; i < NUM_FLAGS; i++) begin
      if (sig_hit(win, i, pos)) begin
        if (i == FLAG_MAG) begin
          if (!scan_flags[FLAG_MAG]) begin
            scan_flags[FLAG_MAG] = 1'b1;
            tag_pos = pos - POS_BITS'(SIG_LEN[FLAG_MAG] - 1);
          end
        end else begin
          scan_flags[i] = 1'b1;
        end
      end
    end
    scan_hist = win[39:0];
    if (unsat) scan_count = scan_count + POS_BITS'(1);
    if (fin) begin
      n = 0;
      if (scan_flags[FLAG_LA1] || scan_flags[FLAG_LA2] || scan_flags[FLAG_LA3]) begin
        v = scan_flags[FLAG_LA1] ? 2'd1 : (scan_flags[FLAG_LA2] ? 2'd2 : 2'd3);
        run[n] = '{KIND_LA, LOADER_CONF, v, 8'h00, 8'h00, 1'b0};
        n++;
      end
      if (scan_flags[FLAG_MAG]) begin
        span_ok = ({1'b0, tag_pos} + (POS_BITS+1)'(TAG_REACH)) < {1'b0, scan_count};
        run[n] = '{KIND_MAG, MAGAZINE_CONF, 2'd0, span_ok ? tag_vol : 8'h00,
                   span_ok ? tag_iss : 8'h00, 1'b0};
        n++;
      end
      if (scan_flags[FLAG_FMT]) begin
        run[n] = '{KIND_FMT, FORMATTER_CONF, 2'd0, 8'h00, 8'h00, 1'b0};
        n++;
      end
      if (scan_flags[FLAG_PUB]) begin
        run[n] = '{KIND_PUB, PUBLISHER_CONF, 2'd0, 8'h00, 8'h00, 1'b0};
        n++;
      end
      if (n == 0) begin
        run[n] = '{KIND_NONE, 7'd0, 2'd0, 8'h00, 8'h00, 1'b0};
        n++;
      end
      run[n-1].last_result = 1'b1;
      for (int k = 0; k < n; k++) due_reports.push_back(run[k]);
      clear_scan();
    end
  endtask

  // valid stays high from one transfer to the next unless a gap is drawn
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.final_byte <= fin;
    do @(posedge clk); while (!in_ch.ready);
    track_signatures(b, fin);
    bytes_sent++;
  endtask

  task automatic send_image();
    for (int k = 0; k < img.size(); k++) send_byte(img[k], k == img.size() - 1);
  endtask

  task automatic add_sig(input int idx);
    for (int k = SIG_LEN[idx] - 1; k >= 0; k--) img.push_back(SIG_BYTES[idx][8*k +: 8]);
  endtask

  function automatic logic [7:0] rand_byte();
    int idx;
    idx = $urandom_range(NUM_FLAGS - 1);
    if ($urandom_range(1)) return 8'($urandom_range(255));
    return SIG_BYTES[idx][8*$urandom_range(SIG_LEN[idx] - 1) +: 8];
  endfunction

  task automatic build_random_image();
    int pick;
    img.delete();
    if ($urandom_range(7) == 0) begin
      img.push_back(rand_byte());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(9);
        if (pick < NUM_FLAGS) begin
          add_sig(pick);
          case ($urandom_range(5))
            0: void'(img.pop_back());
            1: img[$urandom_range(img.size() - 1)] = 8'($urandom_range(255));
            default: ;
          endcase
        end
        repeat ($urandom_range(0, 4)) img.push_back(rand_byte());
      end
    end
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // lone byte, nothing found
    img = {8'hFF};
    send_image();
    // tag at the start, buffer just long enough for volume and issue to count
    img.delete();
    add_sig(FLAG_MAG);
    img = {img, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01};
    send_image();
    // loader variants three and one together: lowest wins
    img.delete();
    add_sig(FLAG_LA3);
    add_sig(FLAG_LA1);
    send_image();
    // formatter then publisher tag completing on the final byte
    img.delete();
    add_sig(FLAG_FMT);
    add_sig(FLAG_PUB);
    send_image();
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    int first;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    first = bytes_sent;
    while (bytes_sent - first < count) begin
      build_random_image();
      send_image();
    end
  endtask

  // sink held off while short buffers keep coming, so the summary queue fills
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 400;
    repeat (12) begin
      img.delete();
      if ($urandom_range(1)) add_sig($urandom_range(NUM_FLAGS - 1));
      img.push_back(rand_byte());
      send_image();
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_reports
    report_t got;
    report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.kind, out_ch.confidence, out_ch.variant, out_ch.volume,
              out_ch.issue, out_ch.last_result};
      if (due_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer kind=%0d conf=%0d var=%0d", $time,
                 got.kind, got.confidence, got.variant);
      end else begin
        want = due_reports.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: expected kind=%0d conf=%0d var=%0d vol=%02h iss=%02h last=%0b",
                   $time, want.kind, want.confidence, want.variant, want.volume,
                   want.issue, want.last_result);
          $display("%0t:   actual kind=%0d conf=%0d var=%0d vol=%02h iss=%02h last=%0b",
                   $time, got.kind, got.confidence, got.variant, got.volume,
                   got.issue, got.last_result);
        end
      end
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    in_ch.final_byte <= 1'b0;
    clear_scan();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(85, 0, 0);
    test_random(85, 50, 0);
    test_random(85, 0, 50);
    test_random(85, 16, 16);
    test_backpressure();
    in_ch.valid <= 1'b0;
    recv_stall_pct = 0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** byte_signature_scanner: PASSED **");
    end else begin
      $display("** byte_signature_scanner: FAILED **");
    end
    $finish;
  end

endmodule
